// ===== src/mle_pkg.sv =====
// Shared types and constants of the monotone lower envelope block.
package mle_pkg;

    localparam int SLOPE_W = 16;
    localparam int OFFSET_W = 32;
    localparam int TAKE_W = 34;
    localparam int VALUE_W = 34;
    localparam int COUNT_W = 11;
    localparam int ENTRY_W = SLOPE_W + OFFSET_W + TAKE_W;

    localparam logic signed [OFFSET_W-1:0] SENTINEL_OFFSET = 32'sd1000000000;
    localparam logic signed [TAKE_W-1:0] FAR_LEFT_X = -34'sd1000000000;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_QUERY = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_EQ_SLOPE  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_MUL,
        ST_WALK_CMP,
        ST_DECIDE,
        ST_DIV,
        ST_QRY_TEST,
        ST_QRY_CMP,
        ST_EVAL_RD,
        ST_EVAL_MUL,
        ST_EVAL_ADD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic    load;
        logic    clear;
        logic    rd_top;
        logic    mul_walk;
        logic    pop;
        logic    div_start;
        logic    push;
        logic    rd_mid;
        logic    bs_step;
        logic    rd_idx;
        logic    mul_eval;
        logic    value_en;
        logic    out_load;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic pop_ok;
        logic d_zero;
        logic slope_eq;
        logic full;
        logic div_done;
        logic count_zero;
        logic out_busy;
    } stat_t;

endpackage

// ===== src/monotone_lower_envelope.sv =====
// A query runs a binary search over the stack (up to 11 steps at 1024 lines), then reads and
// evaluates the chosen line; clear and the unused mode go straight to the result. An add pops
// each top line that the new one makes redundant, then runs the bit-serial takeover division;
// a rejected add skips the division, and so does an add that empties the stack.
// One transaction at a time: the next is accepted in the cycle after its result is registered,
// which waits there until taken. Asynchronous reset leaves only the sentinel on the stack.
module monotone_lower_envelope #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          mode,
    input  logic signed [15:0]                  line_slope,
    input  logic signed [31:0]                  line_offset,
    input  logic signed [15:0]                  query_x,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [33:0]                  envelope_value,
    output logic [1:0]                          status,
    output logic [10:0]                         line_count
);

    mle_pkg::cmd_t  cmd;
    mle_pkg::stat_t stat;

    mle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mle_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .line_slope     (line_slope),
        .line_offset    (line_offset),
        .query_x        (query_x),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .envelope_value (envelope_value),
        .status         (status),
        .line_count     (line_count)
    );

endmodule

// ===== src/mle_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mle_ram #(
    parameter int WIDTH = 82,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mle_div.sv =====
// Bit-serial signed divider giving the takeover x of a new line.
module mle_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic signed [mle_pkg::OFFSET_W:0]    numer,
    input  logic signed [mle_pkg::SLOPE_W:0]     denom,
    output logic                                 done,
    output logic signed [mle_pkg::TAKE_W-1:0]    quot
);

    localparam int NW = mle_pkg::OFFSET_W + 1;
    localparam int DW = mle_pkg::SLOPE_W + 1;
    localparam int CW = $clog2(NW + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [NW-1:0]        qr_reg, qr_next;
    logic [DW-1:0]        rem_reg, rem_next;
    logic [DW-1:0]        dmag_reg, dmag_next;
    logic                 qneg_reg, qneg_next;
    logic                 nneg_reg, nneg_next;
    logic signed [mle_pkg::TAKE_W-1:0] res_reg, res_next;

    logic [DW:0]          rem_sh;
    logic                 fits;
    logic signed [mle_pkg::TAKE_W-1:0] q_signed;

    assign rem_sh = {rem_reg, qr_reg[NW-1]};
    assign fits = rem_sh >= {1'b0, dmag_reg};
    assign q_signed = qneg_reg ? -$signed({1'b0, qr_reg}) : $signed({1'b0, qr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        qr_next = qr_reg;
        rem_next = rem_reg;
        dmag_next = dmag_reg;
        qneg_next = qneg_reg;
        nneg_next = nneg_reg;
        res_next = res_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = CW'(NW);
            qr_next = numer[NW-1] ? NW'(-numer) : NW'(numer);
            rem_next = '0;
            dmag_next = denom[DW-1] ? DW'(-denom) : DW'(denom);
            qneg_next = numer[NW-1] ^ denom[DW-1];
            nneg_next = numer[NW-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CW'(1);
                rem_next = fits ? DW'(rem_sh - {1'b0, dmag_reg}) : DW'(rem_sh);
                qr_next = {qr_reg[NW-2:0], fits};
            end
            else
            begin
                // Truncated quotient, one less when the numerator is negative.
                res_next = q_signed - (nneg_reg ? mle_pkg::TAKE_W'(1) : '0);
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qr_reg <= qr_next;
        rem_reg <= rem_next;
        dmag_reg <= dmag_next;
        qneg_reg <= qneg_next;
        nneg_reg <= nneg_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign quot = res_reg;

endmodule

// ===== src/mle_ctrl.sv =====
// Sequencer that steps the datapath through add, query and clear transactions.
module mle_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [1:0]      mode,
    output logic            in_ready,
    input  mle_pkg::stat_t  stat,
    output mle_pkg::cmd_t   cmd
);

    mle_pkg::state_t  state_reg, state_next;
    mle_pkg::status_t st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mle_pkg::ST_IDLE;
            st_reg <= mle_pkg::STATUS_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        st_next = st_reg;
        cmd = '0;
        cmd.status = st_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            mle_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    st_next = mle_pkg::STATUS_OK;
                    unique case (mle_pkg::mode_t'(mode))
                        mle_pkg::MODE_ADD:   state_next = mle_pkg::ST_WALK_RD;
                        mle_pkg::MODE_QUERY: state_next = mle_pkg::ST_QRY_TEST;
                        mle_pkg::MODE_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            state_next = mle_pkg::ST_FIN;
                        end
                        mle_pkg::MODE_NONE:  state_next = mle_pkg::ST_FIN;
                    endcase
                end
            end
            mle_pkg::ST_WALK_RD:
            begin
                if (stat.d_zero)
                begin
                    state_next = mle_pkg::ST_DECIDE;
                end
                else
                begin
                    cmd.rd_top = 1'b1;
                    state_next = mle_pkg::ST_WALK_MUL;
                end
            end
            mle_pkg::ST_WALK_MUL:
            begin
                cmd.mul_walk = 1'b1;
                state_next = mle_pkg::ST_WALK_CMP;
            end
            mle_pkg::ST_WALK_CMP:
            begin
                if (stat.pop_ok)
                begin
                    cmd.pop = 1'b1;
                    state_next = mle_pkg::ST_WALK_RD;
                end
                else
                begin
                    state_next = mle_pkg::ST_DECIDE;
                end
            end
            mle_pkg::ST_DECIDE:
            begin
                priority if (!stat.d_zero && stat.slope_eq)
                begin
                    st_next = mle_pkg::STATUS_EQ_SLOPE;
                    state_next = mle_pkg::ST_FIN;
                end
                else if (stat.full)
                begin
                    st_next = mle_pkg::STATUS_FULL;
                    state_next = mle_pkg::ST_FIN;
                end
                else if (stat.d_zero)
                begin
                    cmd.push = 1'b1;
                    state_next = mle_pkg::ST_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = mle_pkg::ST_DIV;
                end
            end
            mle_pkg::ST_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.push = 1'b1;
                    state_next = mle_pkg::ST_FIN;
                end
            end
            mle_pkg::ST_QRY_TEST:
            begin
                if (stat.count_zero)
                begin
                    state_next = mle_pkg::ST_EVAL_RD;
                end
                else
                begin
                    cmd.rd_mid = 1'b1;
                    state_next = mle_pkg::ST_QRY_CMP;
                end
            end
            mle_pkg::ST_QRY_CMP:
            begin
                cmd.bs_step = 1'b1;
                state_next = mle_pkg::ST_QRY_TEST;
            end
            mle_pkg::ST_EVAL_RD:
            begin
                cmd.rd_idx = 1'b1;
                state_next = mle_pkg::ST_EVAL_MUL;
            end
            mle_pkg::ST_EVAL_MUL:
            begin
                cmd.mul_eval = 1'b1;
                state_next = mle_pkg::ST_EVAL_ADD;
            end
            mle_pkg::ST_EVAL_ADD:
            begin
                cmd.value_en = 1'b1;
                state_next = mle_pkg::ST_FIN;
            end
            mle_pkg::ST_FIN:
            begin
                // Hold here until the previous result has left the output register.
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = mle_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mle_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/mle_datapath.sv =====
// Line store, stack pointers, walk and search arithmetic, and result register.
module mle_datapath #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  mle_pkg::cmd_t                          cmd,
    output mle_pkg::stat_t                         stat,
    input  logic signed [mle_pkg::SLOPE_W-1:0]     line_slope,
    input  logic signed [mle_pkg::OFFSET_W-1:0]    line_offset,
    input  logic signed [mle_pkg::SLOPE_W-1:0]     query_x,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mle_pkg::VALUE_W-1:0]     envelope_value,
    output logic [1:0]                             status,
    output logic [mle_pkg::COUNT_W-1:0]            line_count
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int SW = mle_pkg::SLOPE_W;
    localparam int OW = mle_pkg::OFFSET_W;
    localparam int TW = mle_pkg::TAKE_W;
    localparam int VW = mle_pkg::VALUE_W;
    localparam int PW = SW + 1 + TW;

    logic signed [SW-1:0]  slope_reg;
    logic signed [OW-1:0]  offset_reg;
    logic signed [SW-1:0]  qx_reg;
    logic [DW-1:0]         depth_reg;
    logic [DW-1:0]         d_reg;
    logic [DW-1:0]         lo_reg;
    logic [DW-1:0]         count_reg;
    logic                  sent_reg;
    logic                  rd_sent_reg;
    logic signed [PW-1:0]  walk_prod_reg;
    logic signed [OW:0]    walk_od_reg;
    logic signed [2*SW-1:0] eval_prod_reg;
    logic signed [OW-1:0]  eval_off_reg;
    logic signed [VW-1:0]  value_reg;
    logic                  out_valid_reg;
    logic signed [VW-1:0]  out_value_reg;
    logic [1:0]            out_status_reg;
    logic [mle_pkg::COUNT_W-1:0] out_count_reg;

    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [AW-1:0]         waddr;
    logic [mle_pkg::ENTRY_W-1:0] ram_wdata;
    logic [mle_pkg::ENTRY_W-1:0] ram_rdata;
    logic signed [SW-1:0]  rd_slope;
    logic signed [OW-1:0]  rd_off;
    logic signed [TW-1:0]  rd_take;
    logic [DW-1:0]         half;
    logic [DW-1:0]         mid;
    logic signed [PW:0]    walk_sum;
    logic signed [SW:0]    slope_diff;
    logic signed [OW:0]    off_diff;
    logic signed [TW-1:0]  take;
    logic signed [TW-1:0]  div_quot;
    logic                  div_done;

    assign half = count_reg >> 1;
    assign mid = lo_reg + half;
    assign slope_diff = (SW + 1)'(rd_slope) - (SW + 1)'(slope_reg);
    assign off_diff = (OW + 1)'(offset_reg) - (OW + 1)'(rd_off);
    assign waddr = AW'(d_reg);

    always_comb
    begin
        priority if (cmd.rd_top)
        begin
            ram_raddr = AW'(d_reg - DW'(1));
        end
        else if (cmd.rd_mid)
        begin
            ram_raddr = AW'(mid);
        end
        else if (lo_reg == '0)
        begin
            ram_raddr = '0;
        end
        else
        begin
            ram_raddr = AW'(lo_reg - DW'(1));
        end
    end

    assign ram_re = cmd.rd_top | cmd.rd_mid | cmd.rd_idx;
    assign take = stat.d_zero ? mle_pkg::FAR_LEFT_X : div_quot;
    assign ram_wdata = {slope_reg, offset_reg, take};

    mle_ram #(
        .WIDTH (mle_pkg::ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.push),
        .waddr (waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry 0 reads as the sentinel until a line is pushed over it.
    always_comb
    begin
        if (rd_sent_reg)
        begin
            rd_slope = '0;
            rd_off = mle_pkg::SENTINEL_OFFSET;
            rd_take = mle_pkg::FAR_LEFT_X;
        end
        else
        begin
            rd_slope = ram_rdata[mle_pkg::ENTRY_W-1 -: SW];
            rd_off = ram_rdata[TW +: OW];
            rd_take = ram_rdata[TW-1:0];
        end
    end

    mle_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .numer (off_diff),
        .denom (slope_diff),
        .done  (div_done),
        .quot  (div_quot)
    );

    // The top line lies above the new one at its takeover x when this is positive.
    assign walk_sum = (PW + 1)'(walk_prod_reg) + (PW + 1)'(walk_od_reg);

    assign stat.pop_ok = !walk_sum[PW] && (walk_sum != '0);
    assign stat.d_zero = (d_reg == '0);
    assign stat.slope_eq = (rd_slope == slope_reg);
    assign stat.full = (d_reg >= DW'(STACK_DEPTH));
    assign stat.div_done = div_done;
    assign stat.count_zero = (count_reg == '0);
    assign stat.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= DW'(1);
            sent_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                depth_reg <= DW'(1);
                sent_reg <= 1'b1;
            end
            else if (cmd.push)
            begin
                depth_reg <= d_reg + DW'(1);
                if (d_reg == '0)
                begin
                    sent_reg <= 1'b0;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slope_reg <= line_slope;
            offset_reg <= line_offset;
            qx_reg <= query_x;
            d_reg <= depth_reg;
            lo_reg <= '0;
            count_reg <= depth_reg;
            value_reg <= '0;
        end
        if (ram_re)
        begin
            rd_sent_reg <= sent_reg && (ram_raddr == '0);
        end
        if (cmd.mul_walk)
        begin
            walk_prod_reg <= slope_diff * rd_take;
            walk_od_reg <= -off_diff;
        end
        if (cmd.pop)
        begin
            d_reg <= d_reg - DW'(1);
        end
        if (cmd.bs_step)
        begin
            if (rd_take < TW'(qx_reg))
            begin
                lo_reg <= mid + DW'(1);
                count_reg <= count_reg - half - DW'(1);
            end
            else
            begin
                count_reg <= half;
            end
        end
        if (cmd.mul_eval)
        begin
            eval_prod_reg <= rd_slope * qx_reg;
            eval_off_reg <= rd_off;
        end
        if (cmd.value_en)
        begin
            value_reg <= VW'(eval_prod_reg) + VW'(eval_off_reg);
        end
        if (cmd.out_load)
        begin
            out_value_reg <= value_reg;
            out_status_reg <= cmd.status;
            out_count_reg <= mle_pkg::COUNT_W'(depth_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign envelope_value = out_value_reg;
    assign status = out_status_reg;
    assign line_count = out_count_reg;

endmodule
